[hw/rtl/assert_macros.svh]
// Assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// Implication checked at every clock edge outside reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hw/rtl/mcnar_pkg.sv]
// Package: shared constants and types of the min-cost colouring block
package mcnar_pkg;

    localparam int MAX_COLORS_DEF  = 16;
    localparam int COST_WIDTH_DEF  = 16;
    localparam int TOTAL_WIDTH_DEF = 32;

    localparam int OUT_W = 32;
    localparam logic [OUT_W-1:0] OUT_MAX = '1;

    // colour count register
    localparam int NUM_COLORS_W = 5;
    localparam logic [NUM_COLORS_W-1:0] NUM_COLORS_RESET = 5'd3;

    // colour counts compared at this width; MAX_COLORS is at most 256
    localparam int K_W = 9;

    // APB register map
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 1;
    localparam logic [REG_IDX_W-1:0] REG_NUM_COLORS = 1'b0;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic first_row;
        logic end_row;
        logic emit;
        logic ok;
    } item_ctrl_t;

endpackage

[hw/rtl/mcnar_front.sv]
// Front end: accepts cost items, tracks colour position and row boundaries
module mcnar_front #(
    parameter int MAX_COLORS = mcnar_pkg::MAX_COLORS_DEF,
    parameter int COST_WIDTH = mcnar_pkg::COST_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [COST_WIDTH-1:0]               cost,
    input  logic                                last_house,
    input  logic [mcnar_pkg::NUM_COLORS_W-1:0]  num_colors,
    output logic                                q_push,
    input  logic                                q_full,
    output logic [COST_WIDTH-1:0]               q_cost,
    output logic [$clog2(MAX_COLORS)-1:0]       q_color,
    output mcnar_pkg::item_ctrl_t               q_ctrl
);

    localparam int CIW = $clog2(MAX_COLORS);
    localparam logic [mcnar_pkg::K_W-1:0] MAX_K = mcnar_pkg::K_W'(MAX_COLORS);

    logic [CIW-1:0]              color_index_reg;
    logic [CIW-1:0]              color_index_next;
    logic                        first_row_reg;
    logic                        first_row_next;
    logic [mcnar_pkg::K_W-1:0]   nc_ext;
    logic [mcnar_pkg::K_W-1:0]   k_eff;
    logic [mcnar_pkg::K_W-1:0]   idx_plus;
    logic                        end_row;

    assign nc_ext   = mcnar_pkg::K_W'(num_colors);
    assign k_eff    = (nc_ext == '0) ? mcnar_pkg::K_W'(1)
                    : ((nc_ext > MAX_K) ? MAX_K : nc_ext);
    assign idx_plus = mcnar_pkg::K_W'(color_index_reg) + mcnar_pkg::K_W'(1);
    assign end_row  = (idx_plus >= k_eff);

    assign full   = q_full;
    assign q_push = push && !q_full;
    assign q_cost = cost;
    assign q_color = color_index_reg;

    always_comb
    begin
        q_ctrl.first_row = first_row_reg;
        q_ctrl.end_row   = end_row;
        q_ctrl.emit      = end_row && last_house;
        q_ctrl.ok        = (k_eff >= mcnar_pkg::K_W'(2)) || first_row_reg;
    end

    always_comb
    begin
        color_index_next = color_index_reg;
        first_row_next   = first_row_reg;
        if (q_push)
        begin
            if (end_row)
            begin
                color_index_next = '0;
                first_row_next   = last_house;
            end
            else
            begin
                color_index_next = color_index_reg + CIW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_index_reg <= '0;
            first_row_reg   <= 1'b1;
        end
        else
        begin
            color_index_reg <= color_index_next;
            first_row_reg   <= first_row_next;
        end
    end

endmodule

[hw/rtl/mcnar_queue.sv]
// Short register queue between front and back ends
module mcnar_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = mcnar_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[hw/rtl/mcnar_back.sv]
// Back end: row DP update with best/second-best totals and result register
module mcnar_back #(
    parameter int MAX_COLORS  = mcnar_pkg::MAX_COLORS_DEF,
    parameter int COST_WIDTH  = mcnar_pkg::COST_WIDTH_DEF,
    parameter int TOTAL_WIDTH = mcnar_pkg::TOTAL_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_empty,
    output logic                            q_pop,
    input  logic [COST_WIDTH-1:0]           q_cost,
    input  logic [$clog2(MAX_COLORS)-1:0]   q_color,
    input  mcnar_pkg::item_ctrl_t           q_ctrl,
    output logic                            empty,
    input  logic                            pop,
    output logic [mcnar_pkg::OUT_W-1:0]     min_total,
    output logic                            feasible
);

    localparam int CIW   = $clog2(MAX_COLORS);
    localparam int TW    = TOTAL_WIDTH;
    localparam int SUM_W = ((COST_WIDTH > TW) ? COST_WIDTH : TW) + 1;
    localparam int OW    = (TW > mcnar_pkg::OUT_W) ? TW : mcnar_pkg::OUT_W;
    localparam logic [TW-1:0]    TOTAL_MAX = '1;
    localparam logic [SUM_W-1:0] MAX_EXT   = SUM_W'(TOTAL_MAX);
    localparam logic [OW-1:0]    OUT_EXT   = OW'(mcnar_pkg::OUT_MAX);

    logic [TW-1:0]  prev_best_reg;
    logic [TW-1:0]  prev_second_reg;
    logic [CIW-1:0] prev_best_color_reg;
    logic [TW-1:0]  cur_best_reg;
    logic [TW-1:0]  cur_second_reg;
    logic [CIW-1:0] cur_best_color_reg;
    logic [TW-1:0]  prev_best_next;
    logic [TW-1:0]  prev_second_next;
    logic [CIW-1:0] prev_best_color_next;
    logic [TW-1:0]  cur_best_next;
    logic [TW-1:0]  cur_second_next;
    logic [CIW-1:0] cur_best_color_next;

    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [mcnar_pkg::OUT_W-1:0] min_total_reg;
    logic                        feasible_reg;

    logic [TW-1:0]    pick;
    logic [SUM_W-1:0] cost_ext;
    logic [SUM_W-1:0] sum;
    logic [TW-1:0]    total;
    logic [TW-1:0]    nb;
    logic [TW-1:0]    ns;
    logic [CIW-1:0]   nc;
    logic [TW-1:0]    res_total;
    logic [OW-1:0]    res_ext;
    logic             out_free;
    logic             step;
    logic             load_out;

    assign out_free = !out_valid_reg || pop;
    assign step     = !q_empty && (!q_ctrl.emit || out_free);
    assign q_pop    = step;
    assign load_out = step && q_ctrl.emit;

    assign pick     = (q_color == prev_best_color_reg) ? prev_second_reg : prev_best_reg;
    assign cost_ext = SUM_W'(q_cost);
    assign sum      = SUM_W'(pick) + cost_ext;

    always_comb
    begin
        if (q_ctrl.first_row)
        begin
            total = (cost_ext >= MAX_EXT) ? TOTAL_MAX : TW'(cost_ext);
        end
        else
        begin
            total = (sum >= MAX_EXT) ? TOTAL_MAX : sum[TW-1:0];
        end
    end

    always_comb
    begin
        nb = cur_best_reg;
        ns = cur_second_reg;
        nc = cur_best_color_reg;
        if (total < cur_best_reg)
        begin
            nb = total;
            ns = cur_best_reg;
            nc = q_color;
        end
        else if (total < cur_second_reg)
        begin
            ns = total;
        end
    end

    assign res_total = q_ctrl.ok ? nb : TOTAL_MAX;
    assign res_ext   = OW'(res_total);

    always_comb
    begin
        prev_best_next       = prev_best_reg;
        prev_second_next     = prev_second_reg;
        prev_best_color_next = prev_best_color_reg;
        cur_best_next        = cur_best_reg;
        cur_second_next      = cur_second_reg;
        cur_best_color_next  = cur_best_color_reg;
        if (step)
        begin
            if (q_ctrl.end_row)
            begin
                cur_best_next       = TOTAL_MAX;
                cur_second_next     = TOTAL_MAX;
                cur_best_color_next = '0;
                if (q_ctrl.emit)
                begin
                    prev_best_next       = TOTAL_MAX;
                    prev_second_next     = TOTAL_MAX;
                    prev_best_color_next = '0;
                end
                else
                begin
                    prev_best_next       = nb;
                    prev_second_next     = ns;
                    prev_best_color_next = nc;
                end
            end
            else
            begin
                cur_best_next       = nb;
                cur_second_next     = ns;
                cur_best_color_next = nc;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_best_reg       <= TOTAL_MAX;
            prev_second_reg     <= TOTAL_MAX;
            prev_best_color_reg <= '0;
            cur_best_reg        <= TOTAL_MAX;
            cur_second_reg      <= TOTAL_MAX;
            cur_best_color_reg  <= '0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            prev_best_reg       <= prev_best_next;
            prev_second_reg     <= prev_second_next;
            prev_best_color_reg <= prev_best_color_next;
            cur_best_reg        <= cur_best_next;
            cur_second_reg      <= cur_second_next;
            cur_best_color_reg  <= cur_best_color_next;
            out_valid_reg       <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            min_total_reg <= (res_ext > OUT_EXT) ? mcnar_pkg::OUT_MAX
                                                 : res_ext[mcnar_pkg::OUT_W-1:0];
            feasible_reg  <= q_ctrl.ok;
        end
    end

    assign empty     = !out_valid_reg;
    assign min_total = min_total_reg;
    assign feasible  = feasible_reg;

endmodule

[hw/rtl/min_cost_no_adjacent_repeat.sv]
// Top level: minimum-cost colouring of a row of houses, no two neighbours alike
//
// Costs enter one per transaction on the push/full side, colours 0..k-1 in order
// with k = num_colors clamped to 1..MAX_COLORS, row after row; last_house marks
// the items of the final row. After its last colour one result transaction
// appears on the empty/pop side: min_total (saturated) and feasible.
// num_colors is written over the APB port (address 0, reset value 3); the user
// must write it only while idle; the block itself does no check of this.
// Throughput: one cost per cycle unless a stalled receiver holds the result
// register; each item needs the back end's add/compare/min update before the next.
// A two-entry queue separates the front end from the back end; when the
// result register is held by a stalled receiver only a row-ending final
// item waits, and full rises once the queue fills behind it.
// Reset empties the queue and result register and starts a new matrix.
module min_cost_no_adjacent_repeat #(
    parameter int MAX_COLORS  = mcnar_pkg::MAX_COLORS_DEF,
    parameter int COST_WIDTH  = mcnar_pkg::COST_WIDTH_DEF,
    parameter int TOTAL_WIDTH = mcnar_pkg::TOTAL_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [COST_WIDTH-1:0]             cost,
    input  logic                              last_house,
    output logic                              empty,
    input  logic                              pop,
    output logic [mcnar_pkg::OUT_W-1:0]       min_total,
    output logic                              feasible,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mcnar_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [mcnar_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [mcnar_pkg::APB_DATA_W-1:0]  prdata,
    output logic                              pready
);

    localparam int CIW    = $clog2(MAX_COLORS);
    localparam int CTRL_W = $bits(mcnar_pkg::item_ctrl_t);
    localparam int QW     = CTRL_W + CIW + COST_WIDTH;

    logic [mcnar_pkg::NUM_COLORS_W-1:0] num_colors_reg;
    logic [mcnar_pkg::REG_IDX_W-1:0]    reg_idx;
    logic                               cfg_wr;

    logic                       q_push;
    logic                       q_full;
    logic [COST_WIDTH-1:0]      f_cost;
    logic [CIW-1:0]             f_color;
    mcnar_pkg::item_ctrl_t      f_ctrl;
    logic [QW-1:0]              q_rd_data;
    logic                       q_empty;
    logic                       q_pop;
    logic [COST_WIDTH-1:0]      b_cost;
    logic [CIW-1:0]             b_color;
    mcnar_pkg::item_ctrl_t      b_ctrl;

    assign reg_idx = paddr[mcnar_pkg::APB_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && (reg_idx == mcnar_pkg::REG_NUM_COLORS);
    assign pready  = 1'b1;
    assign prdata  = (reg_idx == mcnar_pkg::REG_NUM_COLORS)
                   ? mcnar_pkg::APB_DATA_W'(num_colors_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_colors_reg <= mcnar_pkg::NUM_COLORS_RESET;
        end
        else if (cfg_wr)
        begin
            num_colors_reg <= pwdata[mcnar_pkg::NUM_COLORS_W-1:0];
        end
    end

    mcnar_front #(
        .MAX_COLORS (MAX_COLORS),
        .COST_WIDTH (COST_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .cost       (cost),
        .last_house (last_house),
        .num_colors (num_colors_reg),
        .q_push     (q_push),
        .q_full     (q_full),
        .q_cost     (f_cost),
        .q_color    (f_color),
        .q_ctrl     (f_ctrl)
    );

    mcnar_queue #(
        .WIDTH (QW),
        .DEPTH (mcnar_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data ({f_ctrl, f_color, f_cost}),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    assign b_cost  = q_rd_data[COST_WIDTH-1:0];
    assign b_color = q_rd_data[COST_WIDTH+CIW-1:COST_WIDTH];
    assign b_ctrl  = mcnar_pkg::item_ctrl_t'(q_rd_data[QW-1:COST_WIDTH+CIW]);

    mcnar_back #(
        .MAX_COLORS  (MAX_COLORS),
        .COST_WIDTH  (COST_WIDTH),
        .TOTAL_WIDTH (TOTAL_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .q_cost    (b_cost),
        .q_color   (b_color),
        .q_ctrl    (b_ctrl),
        .empty     (empty),
        .pop       (pop),
        .min_total (min_total),
        .feasible  (feasible)
    );

endmodule

[hw/rtl/mcnar_checker.sv]
// Port-level checker for the colouring block, bound to the top level
`include "assert_macros.svh"

module mcnar_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              full,
    input logic                              empty,
    input logic                              pop,
    input logic [mcnar_pkg::OUT_W-1:0]       min_total,
    input logic                              feasible,
    input logic                              psel,
    input logic                              penable,
    input logic                              pwrite,
    input logic [mcnar_pkg::APB_ADDR_W-1:0]  paddr,
    input logic [mcnar_pkg::APB_DATA_W-1:0]  pwdata,
    input logic [mcnar_pkg::APB_DATA_W-1:0]  prdata,
    input logic                              pready
);

    logic nc_sel;
    logic cfg_write;
    logic cfg_read;

    assign nc_sel    = (paddr[mcnar_pkg::APB_ADDR_W-1:2] == mcnar_pkg::REG_NUM_COLORS);
    assign cfg_write = psel && penable && pwrite && pready && nc_sel;
    assign cfg_read  = psel && penable && !pwrite && nc_sel;

    // infeasible results carry a saturated, non-zero total
    `ASSERT_IMPLIES(a_infeasible_total, clk, rst_n, !empty && !feasible, min_total != '0)

    // a waiting result holds until popped
    `ASSERT_NEXT(a_result_held, clk, rst_n, !empty && !pop, !empty && $stable(min_total) && $stable(feasible))

    // both sides come out of reset idle
    `ASSERT_IMPLIES(a_reset_idle, clk, rst_n, $rose(rst_n), empty && !full)

    // colour count reads back what was written
    `ASSERT_NEXT(a_cfg_readback, clk, rst_n, cfg_write, !cfg_read || prdata[mcnar_pkg::NUM_COLORS_W-1:0] == $past(pwdata[mcnar_pkg::NUM_COLORS_W-1:0]))

endmodule

bind min_cost_no_adjacent_repeat mcnar_checker u_checker (.*);
